// ===== hdl/dedup_array_set_table_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dedup array set table
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef DEDUP_ARRAY_SET_TABLE_MACROS_SVH
`define DEDUP_ARRAY_SET_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define DAST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dast assertion failed");
// Next-cycle implication.
`define DAST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dast assertion failed");
`else
`define DAST_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DAST_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/dast_pkg.sv =====
// ----------------------------------------------------------------------------
// dast_pkg
// Types, request codes and status codes of the dedup array set table.
// ----------------------------------------------------------------------------
package dast_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int POS_W = 6;

    localparam logic [2:0] REQ_INSERT   = 3'd0;
    localparam logic [2:0] REQ_REM_ENT  = 3'd1;
    localparam logic [2:0] REQ_REM_RANK = 3'd2;
    localparam logic [2:0] REQ_LOC_ENT  = 3'd3;
    localparam logic [2:0] REQ_LOC_RANK = 3'd4;
    localparam logic [2:0] REQ_PICKUP   = 3'd5;
    localparam logic [2:0] REQ_READ     = 3'd6;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_MISS  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    typedef struct packed {
        logic [2:0] suit;
        logic [3:0] rank;
    } entry_t;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [2:0]       card_suit;
        logic [3:0]       card_rank;
        logic [POS_W-1:0] position;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] found_index;
        logic [2:0] out_suit;
        logic [3:0] out_rank;
        logic [6:0] count_out;
    } res_t;

endpackage

// ===== hdl/dast_ram.sv =====
// ----------------------------------------------------------------------------
// dast_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dast_ram #(
    parameter int DEPTH = dast_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  dast_pkg::entry_t wdata,
    input  logic [AW-1:0]   raddr,
    output dast_pkg::entry_t rdata
);
    import dast_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dast_mod.sv =====
// ----------------------------------------------------------------------------
// dast_mod
// Restoring remainder unit: position modulo count, one bit per cycle.
// ----------------------------------------------------------------------------
module dast_mod #(
    parameter int CW = 7
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [dast_pkg::POS_W-1:0] dividend,
    input  logic [CW-1:0]              divisor,
    output logic                       done,
    output logic [CW-1:0]              rem
);
    import dast_pkg::*;

    localparam int SW = $clog2(POS_W + 1);

    logic [CW-1:0]    rem_reg;
    logic [POS_W-1:0] dvd_reg;
    logic [CW-1:0]    dsr_reg;
    logic [SW-1:0]    step_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CW:0]      trial;
    logic [CW:0]      trial_sub;

    always_comb begin
        trial     = {rem_reg, dvd_reg[POS_W-1]};
        trial_sub = trial - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            dvd_reg  <= dividend;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so it fits CW bits.
            if (trial >= {1'b0, dsr_reg}) begin
                rem_reg <= trial_sub[CW-1:0];
            end else begin
                rem_reg <= trial[CW-1:0];
            end
            dvd_reg  <= {dvd_reg[POS_W-2:0], 1'b0};
            step_reg <= step_reg + 1'b1;
            busy_reg <= (step_reg != SW'(POS_W - 1));
            done_reg <= (step_reg == SW'(POS_W - 1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== hdl/dedup_array_set_table.sv =====
// ----------------------------------------------------------------------------
// dedup_array_set_table
// Ordered table of distinct suit and rank entries with compaction on removal.
// ----------------------------------------------------------------------------
// One request is served at a time and gives one result. Inserts and searches
// walk the entry memory one entry per cycle. A removal stops the search at the
// hit and then closes the gap by moving each later entry down one place, again
// one entry per cycle through the one read port and the one write port. A
// pickup first runs the remainder unit, then fetches and compacts. The input
// is ready only between requests; a finished result waits in the output
// register while the next request is taken, and a stalled output holds the
// next result back.
module dedup_array_set_table #(
    parameter int MAX_ENTRIES = dast_pkg::MAX_ENTRIES_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dast_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output dast_pkg::res_t m_data
);
    import dast_pkg::*;

    `include "dedup_array_set_table_macros.svh"

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_MOD, S_FETCH, S_GRAB, S_EMIT
    } state_t;

    state_t        state_reg;
    req_t          req_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] issue_reg;
    logic [IW-1:0] rd_idx_reg;
    logic          rd_pend_reg;
    logic [IW-1:0] hit_idx_reg;
    logic          hit_valid_reg;
    entry_t        ent_reg;
    logic [2:0]    status_reg;
    logic          m_valid_reg;
    res_t          out_reg;

    entry_t        key;
    entry_t        ram_rdata;
    entry_t        ram_wdata;
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic          by_rank;
    logic          scan_match;
    logic          scan_hit;
    logic          scan_more;
    logic          ins_write;
    logic          accept;
    logic          mod_start;
    logic          mod_done;
    logic [CW-1:0] mod_rem;
    logic          emit_now;
    logic          waddr_ok;

    assign key.suit = req_reg.card_suit;
    assign key.rank = req_reg.card_rank;
    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign emit_now = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);
    assign waddr_ok = (CW'(ram_waddr) < count_reg) ||
                      ((CW'(ram_waddr) == count_reg) && (count_reg != MAX_C));

    always_comb begin
        by_rank    = (req_reg.req_type == REQ_REM_RANK) || (req_reg.req_type == REQ_LOC_RANK);
        scan_match = by_rank ? (ram_rdata.rank == key.rank) : (ram_rdata == key);
        scan_hit   = rd_pend_reg && scan_match;
        scan_more  = issue_reg < count_reg;
        ins_write  = (state_reg == S_SCAN) && !scan_hit && !scan_more &&
                     (req_reg.req_type == REQ_INSERT) && (count_reg != MAX_C);
        mod_start  = accept && (s_data.req_type == REQ_PICKUP) && (count_reg != '0);
    end

    // The shift moves the entry read last cycle one place down while the next
    // one is read, so write and read never meet at the same address.
    always_comb begin
        if (state_reg == S_SHIFT) begin
            ram_we    = rd_pend_reg;
            ram_waddr = rd_idx_reg - 1'b1;
            ram_wdata = ram_rdata;
        end else begin
            ram_we    = ins_write;
            ram_waddr = count_reg[IW-1:0];
            ram_wdata = key;
        end
    end

    dast_ram #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (issue_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    dast_mod #(
        .CW (CW)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (s_data.position),
        .divisor  (count_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            hit_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (emit_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg       <= s_data;
                        hit_valid_reg <= 1'b0;
                        ent_reg       <= '0;
                        rd_pend_reg   <= 1'b0;
                        case (s_data.req_type)
                            REQ_INSERT, REQ_REM_ENT, REQ_REM_RANK,
                            REQ_LOC_ENT, REQ_LOC_RANK: begin
                                status_reg <= ST_OK;
                                issue_reg  <= '0;
                                state_reg  <= S_SCAN;
                            end
                            REQ_PICKUP: begin
                                if (count_reg == '0) begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_EMIT;
                                end else begin
                                    status_reg <= ST_OK;
                                    state_reg  <= S_MOD;
                                end
                            end
                            REQ_READ: begin
                                if (16'(s_data.position) >= 16'(count_reg)) begin
                                    status_reg <= ST_RANGE;
                                    state_reg  <= S_EMIT;
                                end else begin
                                    status_reg <= ST_OK;
                                    issue_reg  <= CW'(s_data.position);
                                    state_reg  <= S_FETCH;
                                end
                            end
                            default: begin
                                status_reg <= ST_OK;
                                state_reg  <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_hit) begin
                        ent_reg       <= ram_rdata;
                        hit_idx_reg   <= rd_idx_reg;
                        hit_valid_reg <= 1'b1;
                        rd_pend_reg   <= 1'b0;
                        case (req_reg.req_type)
                            REQ_INSERT: begin
                                status_reg <= ST_MISS;
                                state_reg  <= S_EMIT;
                            end
                            REQ_REM_ENT, REQ_REM_RANK: begin
                                issue_reg <= CW'(rd_idx_reg) + 1'b1;
                                state_reg <= S_SHIFT;
                            end
                            default: begin
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end else if (scan_more) begin
                        rd_idx_reg  <= issue_reg[IW-1:0];
                        rd_pend_reg <= 1'b1;
                        issue_reg   <= issue_reg + 1'b1;
                    end else begin
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_EMIT;
                        if (req_reg.req_type == REQ_INSERT) begin
                            if (count_reg == MAX_C) begin
                                status_reg <= ST_FULL;
                            end else begin
                                ent_reg       <= key;
                                hit_idx_reg   <= count_reg[IW-1:0];
                                hit_valid_reg <= 1'b1;
                                count_reg     <= count_reg + 1'b1;
                            end
                        end else begin
                            status_reg <= ST_MISS;
                        end
                    end
                end
                S_SHIFT: begin
                    if (scan_more) begin
                        rd_idx_reg  <= issue_reg[IW-1:0];
                        rd_pend_reg <= 1'b1;
                        issue_reg   <= issue_reg + 1'b1;
                    end else begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg) begin
                            count_reg <= count_reg - 1'b1;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        issue_reg <= mod_rem;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    state_reg <= S_GRAB;
                end
                S_GRAB: begin
                    ent_reg       <= ram_rdata;
                    hit_idx_reg   <= issue_reg[IW-1:0];
                    hit_valid_reg <= 1'b1;
                    if (req_reg.req_type == REQ_PICKUP) begin
                        issue_reg   <= issue_reg + 1'b1;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_SHIFT;
                    end else begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit_now) begin
                        out_reg.status      <= status_reg;
                        out_reg.found_index <= hit_valid_reg ? 6'(hit_idx_reg) : 6'd0;
                        out_reg.out_suit    <= ent_reg.suit;
                        out_reg.out_rank    <= ent_reg.rank;
                        out_reg.count_out   <= 7'(count_reg);
                        state_reg           <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    `DAST_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= MAX_C)
    `DAST_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, accept, !s_ready)
    `DAST_ASSERT_IMP(a_write_in_range, aclk, aresetn, ram_we, waddr_ok)
    `DAST_ASSERT_IMP(a_full_status, aclk, aresetn, state_reg == S_EMIT && status_reg == ST_FULL, count_reg == MAX_C)

endmodule
